### hw/rtl/lz77td_pkg.sv
package lz77td_pkg;

  localparam int WINDOW_DEF   = 4096;
  localparam int MAX_COPY_DEF = 63;
  localparam int DIST_W       = 13;
  localparam int LEN_W        = 6;

  typedef struct packed {
    logic [DIST_W-1:0] back_distance;
    logic [LEN_W-1:0]  copy_length;
    logic [7:0]        literal_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_of_token;
    logic       bad_token;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_COPY = 3'b010,
    ST_LIT  = 3'b100
  } state_t;

endpackage

### hw/rtl/lz77td_ring_mem.sv
module lz77td_ring_mem
  import lz77td_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF,
  parameter int AW     = $clog2(WINDOW)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_byte
);

  logic [7:0] mem [WINDOW];
  logic [7:0] rd_q;
  logic [7:0] byp;
  logic       coll;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
    byp  <= wr_data;
  end

  // forward a write that hits the address read in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      coll <= 1'b0;
    end else begin
      coll <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_byte = coll ? byp : rd_q;

endmodule

### hw/rtl/lz77_token_decompressor_unit.sv
// The first byte of a token is registered at the output. The token is accepted in ST_IDLE;
// its bytes come from ST_COPY (if any are copied), then ST_LIT. Throughput: one byte per cycle
// while a token is emitted and out_ready does not stall. Steps: accept the token and start the
// first history read, one per copied byte, one for the literal. An error token emits one result.
// Reset (rst, synchronous): write pointer and byte count to zero; history is not cleared.
module lz77_token_decompressor_unit
  import lz77td_pkg::*;
#(
  parameter int WINDOW   = WINDOW_DEF,
  parameter int MAX_COPY = MAX_COPY_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int AW   = $clog2(WINDOW);
  localparam int CW   = $clog2(WINDOW + 1);
  localparam int CMPW = ((CW > DIST_W) ? CW : DIST_W) + 1;

  state_t          state, state_next;
  logic [AW-1:0]   wp, wp_next;
  logic [CW-1:0]   produced, produced_next;
  logic [AW-1:0]   src, src_next;
  logic [LEN_W-1:0] remaining, remaining_next;
  logic [7:0]      literal, literal_next;
  logic            bad, bad_next;
  logic            out_valid_next;
  out_t            out_data_next;

  logic            can_load;
  logic            wr_en;
  logic [AW-1:0]   rd_addr;
  logic [7:0]      wr_data;
  logic [7:0]      fetched;
  logic [AW-1:0]   wp_inc, src_inc;
  logic [CW-1:0]   produced_inc;
  logic [LEN_W-1:0] len_eff;
  logic [CMPW-1:0] dist_ext, wp_ext, prod_ext;
  logic [AW-1:0]   start;
  logic            dist_bad;

  lz77td_ring_mem #(
    .WINDOW (WINDOW),
    .AW     (AW)
  ) u_ring (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (wp),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_byte (fetched)
  );

  always_comb begin
    wp_inc       = (wp == AW'(WINDOW - 1)) ? '0 : wp + 1'b1;
    src_inc      = (src == AW'(WINDOW - 1)) ? '0 : src + 1'b1;
    produced_inc = (produced == CW'(WINDOW)) ? produced : produced + 1'b1;
    len_eff      = (in_data.copy_length > LEN_W'(MAX_COPY)) ? LEN_W'(MAX_COPY)
                                                             : in_data.copy_length;
    dist_ext     = CMPW'(in_data.back_distance);
    wp_ext       = CMPW'(wp);
    prod_ext     = CMPW'(produced);
    dist_bad     = (dist_ext == '0) || (dist_ext > prod_ext);
    if (dist_ext > wp_ext) begin
      start = AW'(wp_ext + CMPW'(WINDOW) - dist_ext);
    end else begin
      start = AW'(wp_ext - dist_ext);
    end
  end

  assign can_load = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next     = state;
    wp_next        = wp;
    produced_next  = produced;
    src_next       = src;
    remaining_next = remaining;
    literal_next   = literal;
    bad_next       = bad;
    out_valid_next = out_valid && !out_ready;
    out_data_next  = out_data;
    rd_addr        = src;
    wr_en          = 1'b0;
    wr_data        = fetched;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          literal_next = in_data.literal_byte;
          bad_next     = 1'b0;
          if (len_eff != '0 && dist_bad) begin
            bad_next   = 1'b1;
            state_next = ST_LIT;
          end else if (len_eff != '0) begin
            rd_addr        = start;
            src_next       = start;
            remaining_next = len_eff;
            state_next     = ST_COPY;
          end else begin
            state_next = ST_LIT;
          end
        end
      end
      ST_COPY: begin
        if (can_load) begin
          out_valid_next              = 1'b1;
          out_data_next.data_byte     = fetched;
          out_data_next.last_of_token = 1'b0;
          out_data_next.bad_token     = 1'b0;
          wr_en                       = 1'b1;
          wp_next                     = wp_inc;
          produced_next               = produced_inc;
          if (remaining == LEN_W'(1)) begin
            state_next = ST_LIT;
          end else begin
            rd_addr        = src_inc;
            src_next       = src_inc;
            remaining_next = remaining - 1'b1;
          end
        end
      end
      ST_LIT: begin
        if (can_load) begin
          out_valid_next              = 1'b1;
          out_data_next.data_byte     = bad ? 8'd0 : literal;
          out_data_next.last_of_token = 1'b1;
          out_data_next.bad_token     = bad;
          if (!bad) begin
            wr_en         = 1'b1;
            wr_data       = literal;
            wp_next       = wp_inc;
            produced_next = produced_inc;
          end
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wp        <= '0;
      produced  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      wp        <= wp_next;
      produced  <= produced_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    src       <= src_next;
    remaining <= remaining_next;
    literal   <= literal_next;
    bad       <= bad_next;
    out_data  <= out_data_next;
  end

endmodule
